### rtl/spt_pkg.sv
// Shared types and constants for the square page tiler.
// Holds grid sizing, opcode and result codes, controller states and the
// command and status bundles between controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

package spt_pkg;

    localparam int GRID_SIDE  = 16;
    localparam int SIZE_COUNT = 4;

    localparam int COORD_W  = $clog2(GRID_SIDE);
    localparam int DIM_W    = COORD_W + 1;
    localparam int MAX_SPAN = 1 << (SIZE_COUNT - 1);
    localparam int SPAN_W   = $clog2(MAX_SPAN + 1);
    localparam int LVL_W    = (SIZE_COUNT > 1) ? $clog2(SIZE_COUNT) : 1;
    localparam int SUM_W    = ((DIM_W > SPAN_W) ? DIM_W : SPAN_W) + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DIM_W;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b1;
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(GRID_SIDE);

    typedef enum logic {
        OP_CLEAR = 1'b0,
        OP_PLACE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        RES_PLACED  = 2'd0,
        RES_COVERED = 2'd1,
        RES_OUTSIDE = 2'd2,
        RES_CLEARED = 2'd3
    } res_code_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_TAKE,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic decode;
        logic next_level;
        logic off_clr;
        logic off_inc;
        logic take_row;
        logic give_up;
        logic load_result;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic cell_bad;
        logic win_fits;
        logic row_conflict;
        logic last_row;
        logic last_level;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/spt_if.sv
// Valid/ready channel interfaces for the square page tiler.
// Depends on spt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface spt_item_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [spt_pkg::COORD_W-1:0] cell_col;
    logic [spt_pkg::COORD_W-1:0] cell_row;

    modport source (output valid, output opcode, output cell_col, output cell_row,
                    input ready);
    modport sink   (input valid, input opcode, input cell_col, input cell_row,
                    output ready);
endinterface

interface spt_result_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [spt_pkg::LVL_W-1:0]   size_level;
    logic [spt_pkg::SPAN_W-1:0]  span_cells;
    logic [spt_pkg::COORD_W-1:0] page_col;
    logic [spt_pkg::COORD_W-1:0] page_row;

    modport source (output valid, output status, output size_level, output span_cells,
                    output page_col, output page_row, input ready);
    modport sink   (input valid, input status, input size_level, input span_cells,
                    input page_col, input page_row, output ready);
endinterface

`default_nettype wire

### rtl/square_page_tiler.sv
// Top level of the square page tiler: greedy square tiling of a page grid.
// Depends on spt_pkg, spt_if, spt_ctrl and spt_datapath.
//
//   Channel  Direction  Handshake         Carries
//   item     in         valid/ready       opcode, cell_col, cell_row
//   result   out        valid/ready       status, size_level, span_cells, page_col, page_row
//   cfg      in         cfg_we (no wait)  cfg_idx, cfg_data (grid_cols, grid_rows)
//
// One item is in work at a time. A clear or a rejected place item passes through
// acceptance, decode, and the state that loads the result register. A place item
// also checks map rows (only a single one for a window size that leaves the grid)
// and then marks the rows it takes, as the cover map is read and written one row per cycle.
// Rows checked and rows marked never total more than 16.
// Reset frees the whole map at once and sets both grid registers to 16.
// A stalled result is held in the output register; the block stays in its result
// state and accepts no new item until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module square_page_tiler (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    spt_item_if.sink                            item,
    spt_result_if.source                        result,
    input  wire logic                           cfg_we,
    input  wire logic [spt_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [spt_pkg::CFG_DATA_W-1:0] cfg_data
);

    spt_pkg::ctrl_cmd_t cmd;
    spt_pkg::dp_stat_t  stat;

    spt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    spt_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_data       (cfg_data),
        .item_opcode    (item.opcode),
        .item_col       (item.cell_col),
        .item_row       (item.cell_row),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .out_status     (result.status),
        .out_size_level (result.size_level),
        .out_span_cells (result.span_cells),
        .out_page_col   (result.page_col),
        .out_page_row   (result.page_row)
    );

endmodule

`default_nettype wire

### rtl/spt_ctrl.sv
// Controller state machine of the square page tiler.
// Depends on spt_pkg for the state type and the command/status bundles.
`timescale 1ns / 1ps
`default_nettype none

module spt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire spt_pkg::dp_stat_t  stat,
    output spt_pkg::ctrl_cmd_t      cmd
);

    spt_pkg::state_t state_reg;
    spt_pkg::state_t state_next;
    logic            win_bad;

    assign win_bad = !stat.win_fits || stat.row_conflict;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spt_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = spt_pkg::S_DECODE;
                end
            end
            spt_pkg::S_DECODE:
            begin
                if (stat.is_clear || stat.cell_bad)
                begin
                    state_next = spt_pkg::S_RESULT;
                end
                else
                begin
                    state_next = spt_pkg::S_SCAN;
                end
            end
            spt_pkg::S_SCAN:
            begin
                if (win_bad)
                begin
                    if (stat.last_level)
                    begin
                        state_next = spt_pkg::S_RESULT;
                    end
                end
                else if (stat.last_row)
                begin
                    state_next = spt_pkg::S_TAKE;
                end
            end
            spt_pkg::S_TAKE:
            begin
                if (stat.last_row)
                begin
                    state_next = spt_pkg::S_RESULT;
                end
            end
            spt_pkg::S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = spt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            spt_pkg::S_IDLE:
            begin
                item_ready    = 1'b1;
                cmd.load_item = item_valid;
            end
            spt_pkg::S_DECODE:
            begin
                cmd.decode = 1'b1;
            end
            spt_pkg::S_SCAN:
            begin
                // A window that leaves the grid or hits a taken cell drops to
                // the next smaller size and restarts at its first row; at the smallest size it gives up.
                if (win_bad)
                begin
                    if (stat.last_level)
                    begin
                        cmd.give_up = 1'b1;
                    end
                    else
                    begin
                        cmd.next_level = 1'b1;
                        cmd.off_clr    = 1'b1;
                    end
                end
                else if (stat.last_row)
                begin
                    cmd.off_clr = 1'b1;
                end
                else
                begin
                    cmd.off_inc = 1'b1;
                end
            end
            spt_pkg::S_TAKE:
            begin
                cmd.take_row = 1'b1;
                cmd.off_inc  = 1'b1;
            end
            spt_pkg::S_RESULT:
            begin
                cmd.load_result = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/spt_datapath.sv
// Datapath of the square page tiler: cover map rows, grid registers,
// window checking and marking, and the result output register.
// Depends on spt_pkg for widths, codes and the command/status bundles.
`timescale 1ns / 1ps
`default_nettype none

module spt_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire spt_pkg::ctrl_cmd_t                  cmd,
    output spt_pkg::dp_stat_t                        stat,
    input  wire logic                                cfg_we,
    input  wire logic [spt_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  wire logic [spt_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                item_opcode,
    input  wire logic [spt_pkg::COORD_W-1:0]         item_col,
    input  wire logic [spt_pkg::COORD_W-1:0]         item_row,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [1:0]                               out_status,
    output logic [spt_pkg::LVL_W-1:0]                out_size_level,
    output logic [spt_pkg::SPAN_W-1:0]               out_span_cells,
    output logic [spt_pkg::COORD_W-1:0]              out_page_col,
    output logic [spt_pkg::COORD_W-1:0]              out_page_row
);

    localparam int G  = spt_pkg::GRID_SIDE;
    localparam int CW = spt_pkg::COORD_W;
    localparam int SW = spt_pkg::SUM_W;

    logic [G-1:0]                 map_reg [G];
    logic [spt_pkg::DIM_W-1:0]    cols_reg;
    logic [spt_pkg::DIM_W-1:0]    rows_reg;
    spt_pkg::op_t                 op_reg;
    logic [CW-1:0]                col_reg;
    logic [CW-1:0]                row_reg;
    spt_pkg::res_code_t           code_reg;
    logic [spt_pkg::LVL_W-1:0]    lvl_reg;
    logic [spt_pkg::LVL_W-1:0]    lvl_next;
    logic [spt_pkg::SPAN_W-1:0]   off_reg;
    logic [spt_pkg::SPAN_W-1:0]   off_next;
    logic                         out_valid_reg;
    logic [1:0]                   status_reg;
    logic [spt_pkg::LVL_W-1:0]    size_level_reg;
    logic [spt_pkg::SPAN_W-1:0]   span_cells_reg;
    logic [CW-1:0]                page_col_reg;
    logic [CW-1:0]                page_row_reg;

    logic [spt_pkg::SPAN_W-1:0]   span;
    logic [SW-1:0]                col_ext;
    logic [SW-1:0]                row_ext;
    logic [SW-1:0]                span_ext;
    logic [SW-1:0]                col_end;
    logic [SW-1:0]                row_sum;
    logic [CW-1:0]                row_addr;
    logic [G-1:0]                 win_mask;
    logic [G-1:0]                 row_next;
    logic                         outside;
    spt_pkg::res_code_t           decode_code;
    logic                         placed;

    function automatic logic [spt_pkg::DIM_W-1:0] clamp_dim(
        input logic [spt_pkg::DIM_W-1:0] v
    );
        logic [spt_pkg::DIM_W-1:0] r;
        r = v;
        if (v > spt_pkg::DIM_RESET)
        begin
            r = spt_pkg::DIM_RESET;
        end
        return r;
    endfunction

    assign span     = spt_pkg::SPAN_W'(spt_pkg::MAX_SPAN) >> lvl_reg;
    assign col_ext  = SW'(col_reg);
    assign row_ext  = SW'(row_reg);
    assign span_ext = SW'(span);
    assign col_end  = col_ext + span_ext;
    assign row_sum  = row_ext + SW'(off_reg);
    assign row_addr = row_sum[CW-1:0];
    assign outside  = (col_ext >= SW'(cols_reg)) || (row_ext >= SW'(rows_reg));

    always_comb
    begin
        for (int i = 0; i < G; i++)
        begin
            win_mask[i] = (SW'(i) >= col_ext) && (SW'(i) < col_end);
        end
    end

    assign row_next = map_reg[row_addr] | win_mask;
    assign lvl_next = lvl_reg + 1'b1;
    assign off_next = off_reg + 1'b1;

    always_comb
    begin
        if (op_reg == spt_pkg::OP_CLEAR)
        begin
            decode_code = spt_pkg::RES_CLEARED;
        end
        else if (outside)
        begin
            decode_code = spt_pkg::RES_OUTSIDE;
        end
        else if (map_reg[row_reg][col_reg])
        begin
            decode_code = spt_pkg::RES_COVERED;
        end
        else
        begin
            decode_code = spt_pkg::RES_PLACED;
        end
    end

    always_comb
    begin
        stat.is_clear     = (op_reg == spt_pkg::OP_CLEAR);
        stat.cell_bad     = (decode_code != spt_pkg::RES_PLACED);
        stat.win_fits     = (col_end <= SW'(cols_reg)) && (row_ext + span_ext <= SW'(rows_reg));
        stat.row_conflict = |(map_reg[row_addr] & win_mask);
        stat.last_row     = (off_reg == span - 1'b1);
        stat.last_level   = (lvl_reg == spt_pkg::LVL_W'(spt_pkg::SIZE_COUNT - 1));
        stat.out_free     = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg      <= spt_pkg::DIM_RESET;
            rows_reg      <= spt_pkg::DIM_RESET;
            lvl_reg       <= '0;
            off_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < G; r++)
            begin
                map_reg[r] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == spt_pkg::CFG_GRID_COLS)
                begin
                    cols_reg <= clamp_dim(cfg_data);
                end
                else
                begin
                    rows_reg <= clamp_dim(cfg_data);
                end
            end

            if (cmd.decode)
            begin
                lvl_reg <= '0;
                off_reg <= '0;
                if (op_reg == spt_pkg::OP_CLEAR)
                begin
                    for (int r = 0; r < G; r++)
                    begin
                        map_reg[r] <= '0;
                    end
                end
            end

            if (cmd.next_level)
            begin
                lvl_reg <= lvl_next;
            end

            if (cmd.off_clr)
            begin
                off_reg <= '0;
            end
            else if (cmd.off_inc)
            begin
                off_reg <= off_next;
            end

            if (cmd.take_row)
            begin
                map_reg[row_addr] <= row_next;
            end

            if (cmd.load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg  <= spt_pkg::op_t'(item_opcode);
            col_reg <= item_col;
            row_reg <= item_row;
        end

        if (cmd.decode)
        begin
            code_reg <= decode_code;
        end
        else if (cmd.give_up)
        begin
            code_reg <= spt_pkg::RES_COVERED;
        end

        if (cmd.load_result)
        begin
            status_reg <= code_reg;
            if (placed)
            begin
                size_level_reg <= lvl_reg;
                span_cells_reg <= span;
                page_col_reg   <= col_reg;
                page_row_reg   <= row_reg;
            end
            else
            begin
                size_level_reg <= '0;
                span_cells_reg <= '0;
                page_col_reg   <= '0;
                page_row_reg   <= '0;
            end
        end
    end

    assign placed = (code_reg == spt_pkg::RES_PLACED);

    assign out_valid      = out_valid_reg;
    assign out_status     = status_reg;
    assign out_size_level = size_level_reg;
    assign out_span_cells = span_cells_reg;
    assign out_page_col   = page_col_reg;
    assign out_page_row   = page_row_reg;

endmodule

`default_nettype wire
